>>> src/vcd_ppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse-position decoder package
// Shared widths, result codes, gap constants and the result record.
// ----------------------------------------------------------------------------
package vcd_ppd_pkg;

   localparam int PERIODS_W = 10;
   localparam int BYTE_W    = 8;
   localparam int PAIR_W    = 3;

   // Result kinds.
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_EOF   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Framing error codes.
   localparam logic [2:0] ERR_SLOT       = 3'd0;
   localparam logic [2:0] ERR_SOF        = 3'd1;
   localparam logic [2:0] ERR_WIDE_SHORT = 3'd2;
   localparam logic [2:0] ERR_WIDE_LONG  = 3'd3;
   localparam logic [2:0] ERR_FOUR_SHORT = 3'd4;
   localparam logic [2:0] ERR_FOUR_BAD   = 3'd5;
   localparam logic [2:0] ERR_ABSENT     = 3'd0;

   // Gap lengths in pulse periods.
   localparam logic [PERIODS_W-1:0] GAP_SLOT        = 10'd1;
   localparam logic [PERIODS_W-1:0] GAP_EOF         = 10'd2;
   localparam logic [PERIODS_W-1:0] GAP_SOF_FOUR    = 10'd4;
   localparam logic [PERIODS_W-1:0] GAP_SOF_WIDE    = 10'd6;
   localparam logic [PERIODS_W-1:0] WIDE_MAX        = 10'd512;
   localparam logic [PERIODS_W-1:0] WIDE_CARRY_BASE = 10'd511;
   localparam logic [PERIODS_W-1:0] CARRY_NEVER     = 10'd1023;
   localparam logic [PERIODS_W-1:0] FOUR_SOF_CARRY  = 10'd2;
   localparam logic [PERIODS_W-1:0] FOUR_CARRY_BASE = 10'd6;
   localparam logic [PAIR_W-1:0]    PAIRS_PER_BYTE  = 3'd4;
   localparam logic [BYTE_W-1:0]    BYTE_COUNT_MAX  = 8'd255;

   typedef struct packed {
      logic [1:0]        kind;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] byte_count;
      logic              coding_wide;
      logic [2:0]        error_code;
   } rsp_type;

endpackage

>>> src/vcd_pulse_position_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse-position decoder for the vicinity-card reader link
// Decodes measured pulse gaps in 1-of-4 and 1-of-256 coding into bytes,
// end-of-frame markers and framing errors.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)                       | tuser
//  --------+-----------+------------------------------------------+-----------------
//  req_    | in        | periods[9:0], zero fill to 16 bits       | timeout
//  rsp_    | out       | data_byte, byte_count, coding_wide,      | kind[1:0]
//          |           | error_code[2:0], zero fill to 24 bits    |
//
// One gap is taken per clock cycle while rsp_ is not back-pressured. A
// transfer on req_ lands in the input register and is decoded by the core
// once the result register is empty or being drained; its result, if it has
// one, is loaded into the result register at the end of that cycle and
// raises rsp_tvalid. Gaps that give no result (slot pulses, partial 1-of-4
// bytes, start-of-frame gaps, timeouts) still take their turn in the core.
// The decode advances only when the result register is empty or being
// drained, so back pressure on rsp_ holds the input register, which then
// deasserts req_tready. Reset is synchronous and active high; it returns the
// decoder to the start-of-frame search and empties both registers.
module vcd_pulse_position_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // periods[9:0], zeros[15:10]
   input  logic        req_tuser,   // timeout
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // data_byte[7:0], byte_count[15:8],
                                    // coding_wide[16], error_code[19:17], zeros
   output logic [1:0]  rsp_tuser    // kind[1:0]
);

   // Input register: one gap waiting for the decode.
   logic                                in_valid_ff;
   logic                                in_timeout_ff;
   logic [vcd_ppd_pkg::PERIODS_W-1:0]   in_periods_ff;

   // Result register.
   logic                                out_valid_ff;
   vcd_ppd_pkg::rsp_type                out_res_ff;

   logic                                advance;
   logic                                res_valid;
   vcd_ppd_pkg::rsp_type                res;

   // The held gap is decoded whenever its result has somewhere to go.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_timeout_ff <= req_tuser;
         in_periods_ff <= req_tdata[vcd_ppd_pkg::PERIODS_W-1:0];
      end
   end

   vcd_ppd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .timeout   (in_timeout_ff),
      .periods   (in_periods_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tdata  = {4'd0,
                        out_res_ff.error_code,
                        out_res_ff.coding_wide,
                        out_res_ff.byte_count,
                        out_res_ff.data_byte};

endmodule

>>> src/vcd_ppd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pulse-position decoder core
// Frame state registers and the single-pass gap decode for one item.
// ----------------------------------------------------------------------------
module vcd_ppd_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                timeout,
   input  logic [vcd_ppd_pkg::PERIODS_W-1:0]   periods,
   output logic                                res_valid,
   output vcd_ppd_pkg::rsp_type                res
);

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_CODING = 2'd1,
      PH_WIDE   = 2'd2,
      PH_FOUR   = 2'd3
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic                                   expect_ff, expect_in;
   logic [vcd_ppd_pkg::PERIODS_W-1:0]      carry_ff, carry_in;
   logic [vcd_ppd_pkg::BYTE_W-1:0]         shift_ff, shift_in;
   logic [vcd_ppd_pkg::PAIR_W-1:0]         pairs_ff, pairs_in;
   logic [vcd_ppd_pkg::BYTE_W-1:0]         bytes_ff, bytes_in;

   logic [vcd_ppd_pkg::PERIODS_W-1:0]      net;
   logic [vcd_ppd_pkg::PERIODS_W-1:0]      net_m1;
   logic [vcd_ppd_pkg::BYTE_W-1:0]         bytes_inc;
   logic [1:0]                             sym4;
   logic [vcd_ppd_pkg::PAIR_W-1:0]         pairs_inc;

   assign net       = periods - carry_ff;
   assign net_m1    = net - vcd_ppd_pkg::GAP_SLOT;
   assign sym4      = net[2:1];
   assign pairs_inc = pairs_ff + 3'd1;
   assign bytes_inc = (bytes_ff == vcd_ppd_pkg::BYTE_COUNT_MAX) ? bytes_ff
                                                                 : bytes_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      expect_in = expect_ff;
      carry_in  = carry_ff;
      shift_in  = shift_ff;
      pairs_in  = pairs_ff;
      bytes_in  = bytes_ff;
      res_valid = 1'b0;
      res.kind        = vcd_ppd_pkg::KIND_ERROR;
      res.data_byte   = '0;
      res.byte_count  = bytes_ff;
      res.coding_wide = (phase_ff == PH_WIDE);
      res.error_code  = vcd_ppd_pkg::ERR_ABSENT;

      if (timeout) begin
         phase_in  = PH_SEARCH;
         expect_in = 1'b0;
      end else if (expect_ff) begin
         expect_in = 1'b0;
         if (periods != vcd_ppd_pkg::GAP_SLOT) begin
            res_valid      = 1'b1;
            res.error_code = vcd_ppd_pkg::ERR_SLOT;
            phase_in       = PH_SEARCH;
         end
      end else begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (periods == vcd_ppd_pkg::GAP_SLOT) begin
                  phase_in = PH_CODING;
               end
            end
            PH_CODING: begin
               if (periods == vcd_ppd_pkg::GAP_SOF_WIDE ||
                   periods == vcd_ppd_pkg::GAP_SOF_FOUR) begin
                  phase_in  = (periods == vcd_ppd_pkg::GAP_SOF_WIDE) ? PH_WIDE : PH_FOUR;
                  carry_in  = (periods == vcd_ppd_pkg::GAP_SOF_WIDE) ? '0
                                                                     : vcd_ppd_pkg::FOUR_SOF_CARRY;
                  expect_in = 1'b1;
                  shift_in  = '0;
                  pairs_in  = '0;
                  bytes_in  = '0;
               end else begin
                  phase_in        = PH_SEARCH;
                  res_valid       = 1'b1;
                  res.error_code  = vcd_ppd_pkg::ERR_SOF;
                  res.coding_wide = 1'b0;
               end
            end
            PH_WIDE: begin
               res_valid = 1'b1;
               if (carry_ff == vcd_ppd_pkg::CARRY_NEVER || carry_ff > periods) begin
                  res.error_code = vcd_ppd_pkg::ERR_WIDE_SHORT;
                  phase_in       = PH_SEARCH;
               end else if (net > vcd_ppd_pkg::WIDE_MAX) begin
                  res.error_code = vcd_ppd_pkg::ERR_WIDE_LONG;
                  phase_in       = PH_SEARCH;
               end else if (net == vcd_ppd_pkg::GAP_EOF) begin
                  res.kind = vcd_ppd_pkg::KIND_EOF;
                  phase_in = PH_SEARCH;
               end else begin
                  // The symbol value is the slot number; the rest of the
                  // 512-period frame is owed by the next gap.
                  carry_in       = vcd_ppd_pkg::WIDE_CARRY_BASE - net;
                  bytes_in       = bytes_inc;
                  expect_in      = 1'b1;
                  res.kind       = vcd_ppd_pkg::KIND_DATA;
                  res.data_byte  = net_m1[8:1];
                  res.byte_count = bytes_inc;
               end
            end
            PH_FOUR: begin
               if (carry_ff > periods) begin
                  res_valid      = 1'b1;
                  res.error_code = vcd_ppd_pkg::ERR_FOUR_SHORT;
                  phase_in       = PH_SEARCH;
               end else begin
                  carry_in = '0;
                  if (net == vcd_ppd_pkg::GAP_EOF) begin
                     res_valid = 1'b1;
                     res.kind  = vcd_ppd_pkg::KIND_EOF;
                     phase_in  = PH_SEARCH;
                  end else if (net[0] == 1'b0 || net > 10'd7) begin
                     res_valid      = 1'b1;
                     res.error_code = vcd_ppd_pkg::ERR_FOUR_BAD;
                     phase_in       = PH_SEARCH;
                  end else begin
                     carry_in  = vcd_ppd_pkg::FOUR_CARRY_BASE - {7'd0, sym4, 1'b0};
                     shift_in  = {sym4, shift_ff[7:2]};
                     expect_in = 1'b1;
                     pairs_in  = pairs_inc;
                     if (pairs_inc >= vcd_ppd_pkg::PAIRS_PER_BYTE) begin
                        pairs_in       = '0;
                        bytes_in       = bytes_inc;
                        res_valid      = 1'b1;
                        res.kind       = vcd_ppd_pkg::KIND_DATA;
                        res.data_byte  = {sym4, shift_ff[7:2]};
                        res.byte_count = bytes_inc;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_SEARCH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         expect_ff <= 1'b0;
         carry_ff  <= '0;
         shift_ff  <= '0;
         pairs_ff  <= '0;
         bytes_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         expect_ff <= expect_in;
         carry_ff  <= carry_in;
         shift_ff  <= shift_in;
         pairs_ff  <= pairs_in;
         bytes_ff  <= bytes_in;
      end
   end

   a_timeout_idles : assert property (@(posedge clock) disable iff (reset)
      step && timeout |=> phase_ff == PH_SEARCH && !expect_ff)
      else $error("timeout did not return the decoder to the search");

   a_timeout_silent : assert property (@(posedge clock) disable iff (reset)
      timeout |-> !res_valid)
      else $error("timeout produced a result");

   a_pairs_range : assert property (@(posedge clock) disable iff (reset)
      pairs_ff < vcd_ppd_pkg::PAIRS_PER_BYTE)
      else $error("pair counter passed a full byte");

   a_error_returns : assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.kind == vcd_ppd_pkg::KIND_ERROR
      |=> phase_ff == PH_SEARCH && !expect_ff)
      else $error("framing error did not restart the search");

endmodule

>>> bench/tb_vcd_pulse_position_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the pulse-position decoder
// Drives measured gaps and timeouts into the decoder and predicts every byte,
// end of frame and framing error that must come back. Each result is compared
// field by field. The stimulus starts with hand-picked frames. It then mixes
// well-formed 1-of-4 and 1-of-256 frames, broken frames and random noise under
// bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_vcd_pulse_position_decoder;

   // Where the decoder stands in the frame.
   typedef enum logic [1:0] {
      HUNT_SOF,     // waiting for the single pulse of a start of frame
      HUNT_CODING,  // waiting for the 4- or 6-period coding gap
      SYM_WIDE,     // 1-of-256 symbols
      SYM_FOUR      // 1-of-4 symbols
   } link_phase_type;

   // -------------------------------------------------------------------------
   // Scoreboard. It keeps its own copy of the decoder state, works out the
   // result of each accepted gap, and holds the results still to arrive.
   // -------------------------------------------------------------------------
   class gap_scoreboard;
      link_phase_type                        phase;
      bit                                    expect_pulse;
      logic [vcd_ppd_pkg::PERIODS_W-1:0]     carry;
      logic [vcd_ppd_pkg::BYTE_W-1:0]        byte_shift;
      logic [vcd_ppd_pkg::PAIR_W-1:0]        pair_count;
      logic [vcd_ppd_pkg::BYTE_W-1:0]        frame_bytes;
      vcd_ppd_pkg::rsp_type                  pending_rsp[$];
      int                                    mismatches;

      function new();
         phase        = HUNT_SOF;
         expect_pulse = 1'b0;
         carry        = '0;
         byte_shift   = '0;
         pair_count   = '0;
         frame_bytes  = '0;
         mismatches   = 0;
      endfunction

      // Queues one result; the byte count and coding come from the state.
      function void push_rsp(logic [1:0] kind, logic [vcd_ppd_pkg::BYTE_W-1:0] data,
                             logic [2:0] code);
         vcd_ppd_pkg::rsp_type r;
         r.kind        = kind;
         r.data_byte   = data;
         r.byte_count  = frame_bytes;
         r.coding_wide = (phase == SYM_WIDE);
         r.error_code  = code;
         pending_rsp.push_back(r);
      endfunction

      // A framing error always drops the decoder back to the search.
      function void raise_error(logic [2:0] code);
         push_rsp(vcd_ppd_pkg::KIND_ERROR, '0, code);
         phase        = HUNT_SOF;
         expect_pulse = 1'b0;
      endfunction

      function void count_byte();
         if (frame_bytes != vcd_ppd_pkg::BYTE_COUNT_MAX) begin
            frame_bytes = frame_bytes + 8'd1;
         end
      endfunction

      // Called once per accepted input transfer.
      function void note_gap(bit timeout, logic [vcd_ppd_pkg::PERIODS_W-1:0] periods);
         logic [vcd_ppd_pkg::PERIODS_W-1:0] p;
         logic [vcd_ppd_pkg::PERIODS_W-1:0] p_less;
         logic [1:0]                        sym;
         if (timeout) begin
            phase        = HUNT_SOF;
            expect_pulse = 1'b0;
            return;
         end
         if (expect_pulse) begin
            expect_pulse = 1'b0;
            if (periods != vcd_ppd_pkg::GAP_SLOT) begin
               raise_error(vcd_ppd_pkg::ERR_SLOT);
            end
            return;
         end
         case (phase)
            HUNT_SOF: begin
               if (periods == vcd_ppd_pkg::GAP_SLOT) begin
                  phase = HUNT_CODING;
               end
            end
            HUNT_CODING: begin
               if (periods == vcd_ppd_pkg::GAP_SOF_WIDE ||
                   periods == vcd_ppd_pkg::GAP_SOF_FOUR) begin
                  phase        = (periods == vcd_ppd_pkg::GAP_SOF_WIDE) ? SYM_WIDE
                                                                        : SYM_FOUR;
                  carry        = (periods == vcd_ppd_pkg::GAP_SOF_WIDE) ? '0
                                 : vcd_ppd_pkg::FOUR_SOF_CARRY;
                  expect_pulse = 1'b1;
                  byte_shift   = '0;
                  pair_count   = '0;
                  frame_bytes  = '0;
               end else begin
                  // Still in the coding phase here, so coding_wide reads 0.
                  push_rsp(vcd_ppd_pkg::KIND_ERROR, '0, vcd_ppd_pkg::ERR_SOF);
                  phase = HUNT_SOF;
               end
            end
            SYM_WIDE: begin
               if (carry == vcd_ppd_pkg::CARRY_NEVER || carry > periods) begin
                  raise_error(vcd_ppd_pkg::ERR_WIDE_SHORT);
                  return;
               end
               p = periods - carry;
               if (p > vcd_ppd_pkg::WIDE_MAX) begin
                  raise_error(vcd_ppd_pkg::ERR_WIDE_LONG);
                  return;
               end
               if (p == vcd_ppd_pkg::GAP_EOF) begin
                  push_rsp(vcd_ppd_pkg::KIND_EOF, '0, vcd_ppd_pkg::ERR_ABSENT);
                  phase = HUNT_SOF;
                  return;
               end
               // A 512-period symbol wraps the carry to the never-met value.
               carry  = vcd_ppd_pkg::WIDE_CARRY_BASE - p;
               p_less = p - 10'd1;
               count_byte();
               expect_pulse = 1'b1;
               push_rsp(vcd_ppd_pkg::KIND_DATA, p_less[8:1], vcd_ppd_pkg::ERR_ABSENT);
            end
            default: begin
               if (carry > periods) begin
                  raise_error(vcd_ppd_pkg::ERR_FOUR_SHORT);
                  return;
               end
               p     = periods - carry;
               carry = '0;
               if (p == vcd_ppd_pkg::GAP_EOF) begin
                  push_rsp(vcd_ppd_pkg::KIND_EOF, '0, vcd_ppd_pkg::ERR_ABSENT);
                  phase = HUNT_SOF;
                  return;
               end
               if (p != 10'd1 && p != 10'd3 && p != 10'd5 && p != 10'd7) begin
                  raise_error(vcd_ppd_pkg::ERR_FOUR_BAD);
                  return;
               end
               p_less       = p - 10'd1;
               sym          = p_less[2:1];
               carry        = vcd_ppd_pkg::FOUR_CARRY_BASE - {7'd0, sym, 1'b0};
               byte_shift   = {sym, byte_shift[7:2]};
               pair_count   = pair_count + 3'd1;
               expect_pulse = 1'b1;
               if (pair_count >= vcd_ppd_pkg::PAIRS_PER_BYTE) begin
                  pair_count = '0;
                  count_byte();
                  push_rsp(vcd_ppd_pkg::KIND_DATA, byte_shift, vcd_ppd_pkg::ERR_ABSENT);
               end
            end
         endcase
      endfunction

      // Every mismatch prints one line and is counted.
      task report(string msg);
         $display("%0t ns mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // Called once per accepted result transfer.
      task check_rsp(vcd_ppd_pkg::rsp_type got);
         vcd_ppd_pkg::rsp_type want;
         if (pending_rsp.size() == 0) begin
            report($sformatf("result with nothing pending (kind %0d)", got.kind));
            return;
         end
         want = pending_rsp.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.data_byte !== want.data_byte)
            report($sformatf("data_byte %0h, want %0h", got.data_byte, want.data_byte));
         if (got.byte_count !== want.byte_count)
            report($sformatf("byte_count %0d, want %0d", got.byte_count,
                             want.byte_count));
         if (got.coding_wide !== want.coding_wide)
            report($sformatf("coding_wide %0d, want %0d", got.coding_wide,
                             want.coding_wide));
         if (got.error_code !== want.error_code)
            report($sformatf("error_code %0d, want %0d", got.error_code,
                             want.error_code));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals and the block under test.
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // periods[9:0], zeros[15:10]
   logic        req_tuser;   // timeout
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // data_byte[7:0], byte_count[15:8], coding_wide[16],
                             // error_code[19:17], zeros[23:20]
   logic [1:0]  rsp_tuser;   // kind[1:0]

   gap_scoreboard        sb;
   vcd_ppd_pkg::rsp_type seen_rsp;
   int                   items_sent;
   int                   burst_left;
   int                   rx_cycle;
   int                   rx_mode;

   vcd_pulse_position_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the decoder hangs. The slowest legal run is far below
   // this, even with every stall the receiver can throw at it.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Sender. It works in bursts: after a burst of random length the valid
   // drops for a random number of cycles, sometimes none at all. Inputs only
   // change at the falling edge; the handshake is sampled at the rising edge.
   // -------------------------------------------------------------------------
   task send_gap(bit timeout, logic [vcd_ppd_pkg::PERIODS_W-1:0] periods);
      int idle;
      idle = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
         idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (idle > 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (idle - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= timeout;
      req_tdata  <= {6'b0, periods};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_gap(timeout, periods);
      items_sent++;
   endtask

   // One frame: start of frame, nsym symbols each after its slot pulse, then
   // end of frame, or at times a timeout. When break_odds is not zero, each
   // symbol has a chance of being replaced by a broken one, which ends the frame.
   task run_frame(bit wide, int nsym, int break_odds);
      int i;
      int p;
      int how;
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, wide ? vcd_ppd_pkg::GAP_SOF_WIDE : vcd_ppd_pkg::GAP_SOF_FOUR);
      for (i = 0; i < nsym; i++) begin
         // A never-met carry already failed the frame; stop here.
         if (sb.phase != SYM_WIDE && sb.phase != SYM_FOUR) return;
         if (break_odds != 0 && $urandom_range(1, break_odds) == 1) begin
            how = $urandom_range(0, 3);
            if (how == 0) begin
               // Slot gap that is not a single period.
               p = $urandom_range(0, 1023);
               send_gap(1'b0, 10'((p == 1) ? 0 : p));
            end else if (how == 1) begin
               send_gap(1'b1, 10'($urandom_range(0, 1023)));
            end else if (how == 2 && sb.carry != 0 &&
                         sb.carry != vcd_ppd_pkg::CARRY_NEVER) begin
               // Gap shorter than the periods still owed.
               send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
               send_gap(1'b0, 10'($urandom_range(0, sb.carry - 1)));
            end else begin
               send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
               if (wide) begin
                  p = (sb.carry <= 510) ? $urandom_range(513, 1023 - sb.carry) : 0;
               end else begin
                  p = $urandom_range(0, 20);
                  if (p == 2 || (p <= 7 && p[0])) p = p + 8;
               end
               send_gap(1'b0, 10'(sb.carry + p));
            end
            return;
         end
         send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
         if (wide) begin
            how = $urandom_range(0, 9);
            if (how < 6) begin
               p = $urandom_range(0, 20);
            end else if (how < 9) begin
               p = $urandom_range(0, 512);
            end else begin
               case ($urandom_range(0, 3))
                  0:       p = 0;
                  1:       p = 1;
                  2:       p = 511;
                  default: p = 512;
               endcase
            end
            if (p == vcd_ppd_pkg::GAP_EOF) p = 3;
         end else begin
            p = 2 * $urandom_range(0, 3) + 1;
         end
         send_gap(1'b0, 10'(sb.carry + p));
      end
      if (sb.phase != SYM_WIDE && sb.phase != SYM_FOUR) return;
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      if ($urandom_range(0, 9) == 0) begin
         send_gap(1'b1, 10'($urandom_range(0, 1023)));
      end else begin
         send_gap(1'b0, sb.carry + vcd_ppd_pkg::GAP_EOF);
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver. Its ready follows a pattern that is picked anew at random
   // throughout the run: always ready, half, three quarters or one quarter of
   // the time. Once in the run it holds off while the sender keeps offering
   // gaps, so both registers fill and the input stalls.
   // -------------------------------------------------------------------------
   initial begin
      rsp_tready = 1'b0;
      rx_cycle   = 0;
      rx_mode    = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
         if (rx_cycle >= 1500 && rx_cycle < 1800) begin
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 0);
               2:       rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Result monitor: every result transfer is checked against the oldest
   // pending expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.kind        = rsp_tuser;
         seen_rsp.data_byte   = rsp_tdata[7:0];
         seen_rsp.byte_count  = rsp_tdata[15:8];
         seen_rsp.coding_wide = rsp_tdata[16];
         seen_rsp.error_code  = rsp_tdata[19:17];
         sb.check_rsp(seen_rsp);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int n;
      int choice;
      int drain;
      sb         = new();
      items_sent = 0;
      burst_left = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Search phase: gaps other than one period and a timeout are ignored.
      send_gap(1'b0, 10'd0);
      send_gap(1'b0, 10'd1023);
      send_gap(1'b1, vcd_ppd_pkg::GAP_SLOT);
      // Single pulse followed by a wrong coding gap: bad start of frame.
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, 10'd5);
      // 1-of-4 frame with symbols 0, 3, 2, 1: one byte of 0x6C, then the
      // end of frame. Each gap carries the periods owed by the last symbol.
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SOF_FOUR);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, 10'd3);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, 10'd13);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, 10'd5);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, 10'd5);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, 10'd6);
      // 1-of-256 frame: a zero-period symbol decodes to 255, then a symbol
      // of exactly 512 periods, whose carry no gap can meet, so the next
      // symbol fails as too short.
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SOF_WIDE);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, 10'd0);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, 10'd1023);
      send_gap(1'b0, vcd_ppd_pkg::GAP_SLOT);
      send_gap(1'b0, 10'd1023);

      // A long 1-of-256 frame saturates the byte count unless a 512-period symbol ends it.
      run_frame(1'b1, 260, 0);

      // Random part: mostly frames with random content, some broken, and
      // bursts of noise in between.
      while (items_sent < 1700) begin
         choice = $urandom_range(0, 9);
         if (choice < 4) begin
            n = 4 * $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) n = n + $urandom_range(1, 3);
            run_frame(1'b0, n, 30);
         end else if (choice < 7) begin
            run_frame(1'b1, $urandom_range(0, 8), 30);
         end else begin
            // Noise: short gaps make chance starts of frame likely.
            repeat ($urandom_range(3, 20)) begin
               send_gap($urandom_range(0, 7) == 0,
                        10'($urandom_range(0, 1) ? $urandom_range(0, 8)
                                                 : $urandom_range(0, 1023)));
            end
         end
      end
      @(negedge clock) req_tvalid <= 1'b0;

      // Let the last results drain, then keep the clock running so that any
      // stray result still shows up.
      drain = 0;
      while (sb.pending_rsp.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (sb.pending_rsp.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.pending_rsp.size()));
      end
      if (sb.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
